// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CXC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define CXC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/cxc_pkg.sv
package cxc_pkg;

    // block geometry and fixed byte values
    localparam int BLOCK_BYTES = 16;
    localparam int KEY_BYTES   = 16;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;
    localparam logic [7:0] PAD_BYTE = 8'h20;
    localparam logic [4:0] KEY_LEN_MAX = 5'(KEY_BYTES);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE_DECRYPT = 3'd0,
        REG_KEY_LOW      = 3'd1,
        REG_KEY_HIGH     = 3'd2,
        REG_KEY_LENGTH   = 3'd3,
        REG_IV_LOW       = 3'd4,
        REG_IV_HIGH      = 3'd5
    } reg_index_t;

    // configuration register contents
    typedef struct packed {
        logic        mode_decrypt;
        logic [63:0] key_low;
        logic [63:0] key_high;
        logic [4:0]  key_length;
        logic [63:0] iv_low;
        logic [63:0] iv_high;
    } cfg_t;

    // contents of the input register
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       end_of_message;
    } stage_t;

    // result handed to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       out_last;
    } result_t;

    // byte n of a 16-byte value split over two 64-bit words, zero beyond
    function automatic logic [7:0] byte_of(input logic [63:0] lo, input logic [63:0] hi,
                                           input int unsigned n);
        logic [7:0] b;
        b = 8'h00;
        if (n < 8)
            b = lo[8*n +: 8];
        else if (n < 16)
            b = hi[8*(n-8) +: 8];
        return b;
    endfunction

endpackage

// File: src/cxc_if.sv
// request channel carrying input bytes
interface cxc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

// request channel carrying result bytes
interface cxc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: src/cbc_xor_byte_cipher_core.sv
// CBC-style byte cipher over blocks of BLOCK_BYTES bytes, with a repeating-key xor as the
// block function. One byte enters per cycle unless the output stalls or padding is pending,
// and passes through an input register and an output register with one xor-and-step pass
// between them. When an encrypted message ends inside a block, space padding bytes follow
// its last byte at one per cycle while the output is free, and no new byte is taken until
// the block is complete (up to BLOCK_BYTES - 1 padding bytes). The iv is copied into the
// chain on the first byte of a message, key and mode are read on every byte.
module cbc_xor_byte_cipher_core #(
    parameter int BLOCK_BYTES = cxc_pkg::BLOCK_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    cxc_in_if.sink                         ingress,
    cxc_out_if.source                      egress,
    input  logic                           cfg_we,
    input  logic [cxc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cxc_pkg::CFG_W-1:0]      cfg_wdata
);

    cxc_pkg::cfg_t    cfg;
    cxc_pkg::stage_t  stage;
    cxc_pkg::result_t result;
    logic             consume;
    logic             out_free;

    logic             in_valid_reg;
    logic [7:0]       in_data_reg;
    logic             in_last_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    // configuration registers
    cxc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // input register
    assign ingress.ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (ingress.ready)
            in_valid_reg <= ingress.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ingress.valid && ingress.ready)
        begin
            in_data_reg <= ingress.data_byte;
            in_last_reg <= ingress.end_of_message;
        end
    end

    assign stage.valid          = in_valid_reg;
    assign stage.data_byte      = in_data_reg;
    assign stage.end_of_message = in_last_reg;

    // cipher step
    cxc_crypt_unit #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_crypt (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .stage    (stage),
        .out_free (out_free),
        .consume  (consume),
        .result   (result)
    );

    // output register
    assign out_free = !out_valid_reg || egress.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= result.valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && result.valid)
        begin
            out_byte_reg <= result.out_byte;
            out_last_reg <= result.out_last;
        end
    end

    assign egress.valid    = out_valid_reg;
    assign egress.out_byte = out_byte_reg;
    assign egress.out_last = out_last_reg;

endmodule

// File: src/cxc_cfg_regs.sv
module cxc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cxc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cxc_pkg::CFG_W-1:0]      cfg_wdata,
    output cxc_pkg::cfg_t                  cfg
);

    cxc_pkg::cfg_t cfg_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_decrypt <= 1'b0;
            cfg_reg.key_low      <= '0;
            cfg_reg.key_high     <= '0;
            cfg_reg.key_length   <= cxc_pkg::KEY_LEN_MAX;
            cfg_reg.iv_low       <= '0;
            cfg_reg.iv_high      <= '0;
        end
        else if (cfg_we)
        begin
            case (cxc_pkg::reg_index_t'(cfg_index))
                cxc_pkg::REG_MODE_DECRYPT: cfg_reg.mode_decrypt <= cfg_wdata[0];
                cxc_pkg::REG_KEY_LOW:      cfg_reg.key_low      <= cfg_wdata;
                cxc_pkg::REG_KEY_HIGH:     cfg_reg.key_high     <= cfg_wdata;
                cxc_pkg::REG_KEY_LENGTH:   cfg_reg.key_length   <= cfg_wdata[4:0];
                cxc_pkg::REG_IV_LOW:       cfg_reg.iv_low       <= cfg_wdata;
                cxc_pkg::REG_IV_HIGH:      cfg_reg.iv_high      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/cxc_crypt_unit.sv
`include "assert_macros.svh"

module cxc_crypt_unit #(
    parameter int BLOCK_BYTES = cxc_pkg::BLOCK_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cxc_pkg::cfg_t     cfg,
    input  cxc_pkg::stage_t   stage,
    input  logic              out_free,
    output logic              consume,
    output cxc_pkg::result_t  result
);

    localparam int PW = $clog2(BLOCK_BYTES);
    localparam logic [PW-1:0] POS_LAST = PW'(BLOCK_BYTES - 1);

    // chain bytes and message state
    logic [7:0]    chain_reg [BLOCK_BYTES];
    logic [PW-1:0] pos_reg;
    logic [4:0]    kidx_reg;
    logic          started_reg;
    logic          pad_reg;

    logic          fire;
    logic          start;
    logic [PW-1:0] pos_cur;
    logic [PW-1:0] pos_nx;
    logic          pos_wrap;
    logic [4:0]    kidx_cur;
    logic [4:0]    kidx_inc;
    logic [4:0]    kidx_nx;
    logic [4:0]    key_len;
    logic [7:0]    key_byte;
    logic [7:0]    chain_cur;
    logic [7:0]    src_byte;
    logic [7:0]    res_byte;
    logic          dec;
    logic          last_in;
    logic          need_pad;
    logic          pad_done;

    // step control: padding takes priority over new input
    assign fire    = out_free && (pad_reg || stage.valid);
    assign consume = out_free && !pad_reg && stage.valid;
    assign start   = consume && !started_reg;

    // current position and key index, reset to message start on the first byte
    assign pos_cur  = start ? '0 : pos_reg;
    assign kidx_cur = start ? 5'd1 : kidx_reg;

    // effective key length, clamped into one to sixteen
    always_comb
    begin
        if (cfg.key_length == 5'd0)
            key_len = 5'd1;
        else if (cfg.key_length > cxc_pkg::KEY_LEN_MAX)
            key_len = cxc_pkg::KEY_LEN_MAX;
        else
            key_len = cfg.key_length;
    end

    // key byte, zero at or beyond the key length
    assign key_byte = (kidx_cur < key_len)
                    ? cxc_pkg::byte_of(cfg.key_low, cfg.key_high, int'(kidx_cur[3:0]))
                    : 8'h00;

    // chain byte at the current position, straight from the iv on message start
    assign chain_cur = start ? cxc_pkg::byte_of(cfg.iv_low, cfg.iv_high, int'(pos_cur))
                             : chain_reg[pos_cur];

    // xor path
    assign src_byte = pad_reg ? cxc_pkg::PAD_BYTE : stage.data_byte;
    assign dec      = !pad_reg && cfg.mode_decrypt;
    assign res_byte = src_byte ^ chain_cur ^ key_byte;

    // position and key index stepping
    assign pos_wrap = (pos_cur == POS_LAST);
    assign pos_nx   = pos_wrap ? '0 : pos_cur + PW'(1);
    assign kidx_inc = kidx_cur + 5'd1;
    assign kidx_nx  = pos_wrap ? 5'd1 : ((kidx_inc >= key_len) ? 5'd0 : kidx_inc);

    // end of message and padding decisions
    assign last_in  = consume && stage.end_of_message;
    assign need_pad = last_in && !cfg.mode_decrypt && !pos_wrap;
    assign pad_done = pad_reg && pos_wrap;

    assign result.valid    = fire;
    assign result.out_byte = res_byte;
    assign result.out_last = (last_in && !need_pad) || pad_done;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            kidx_reg    <= 5'd1;
            started_reg <= 1'b0;
            pad_reg     <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg     <= pos_nx;
            kidx_reg    <= kidx_nx;
            started_reg <= !result.out_last;
            pad_reg     <= need_pad || (pad_reg && !pos_wrap);
        end
    end

    // chain update: iv load on message start, then the feedback byte
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int n = 0; n < BLOCK_BYTES; n++)
            begin
                if (PW'(n) == pos_cur)
                    chain_reg[n] <= dec ? src_byte : res_byte;
                else if (start)
                    chain_reg[n] <= cxc_pkg::byte_of(cfg.iv_low, cfg.iv_high, n);
            end
        end
    end

    // checks
    `CXC_ASSERT_SAME(a_pad_blocks_input, pad_reg, !consume, "input taken while padding")
    `CXC_ASSERT_SAME(a_pad_inside_message, pad_reg, started_reg, "padding outside a message")
    `CXC_ASSERT_NEXT(a_no_pad_on_decrypt, last_in && cfg.mode_decrypt, !pad_reg, "decrypt padded")
    `CXC_ASSERT_SAME(a_pad_ends_on_boundary, fire && pad_reg, result.out_last == pos_wrap, "pad end off boundary")

endmodule
